// ===== src/nlp_pkg.sv =====
// Shared types, constants and the control store of the permutation stepper.
// Depends on nothing; used by nlp_sequencer and next_lexicographic_permutation.
package nlp_pkg;

  // Default geometry of the row
  localparam int ROW_LENGTH_DEF    = 10;
  localparam int ELEMENT_WIDTH_DEF = 4;

  // Fixed field widths of the channels
  localparam int POS_W     = 4;
  localparam int IN_ELEM_W = 4;
  localparam int PACKED_W  = 40;
  localparam int DECIMAL_W = 34;

  // Control store addressing
  localparam int UPC_W = 4;
  typedef logic [UPC_W-1:0] upc_t;

  localparam upc_t ST_IDLE  = 4'd0;
  localparam upc_t ST_WRITE = 4'd1;
  localparam upc_t ST_PINIT = 4'd2;
  localparam upc_t ST_PSCAN = 4'd3;
  localparam upc_t ST_NOPIV = 4'd4;
  localparam upc_t ST_SINIT = 4'd5;
  localparam upc_t ST_SSCAN = 4'd6;
  localparam upc_t ST_RINIT = 4'd7;
  localparam upc_t ST_RLOAD = 4'd8;
  localparam upc_t ST_RSWAP = 4'd9;
  localparam upc_t ST_KINIT = 4'd10;
  localparam upc_t ST_PACK  = 4'd11;
  localparam upc_t ST_DONE  = 4'd12;

  // Datapath operation of one step
  typedef enum logic [3:0] {
    OP_IDLE,
    OP_WRITE,
    OP_PINIT,
    OP_PSCAN,
    OP_NOPIV,
    OP_SINIT,
    OP_SSCAN,
    OP_RINIT,
    OP_RLOAD,
    OP_RSWAP,
    OP_KINIT,
    OP_PACK,
    OP_DONE
  } op_t;

  // Source of the row read address
  typedef enum logic [1:0] {
    RS_A,
    RS_B,
    RS_K,
    RS_LAST
  } rsel_t;

  // Branch conditions
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_IN_WRITE,
    C_IN_ADV,
    C_LESS,
    C_A_ZERO,
    C_GREATER,
    C_A_GE_B,
    C_K_LAST,
    C_OUT_FREE
  } cond_t;

  typedef struct packed {
    op_t   op;
    rsel_t rsel;
    cond_t cond_a;
    upc_t  tgt_a;
    cond_t cond_b;
    upc_t  tgt_b;
    logic  hold;    // stay on this step when no branch is taken
  } ucode_t;

  // Datapath status seen by the sequencer
  typedef struct packed {
    logic in_write;
    logic in_adv;
    logic less;
    logic a_zero;
    logic greater;
    logic a_ge_b;
    logic k_last;
    logic out_free;
  } flags_t;

  function automatic ucode_t ucode_rom(input upc_t upc);
    case (upc)
      ST_IDLE:  return '{OP_IDLE,  RS_A,    C_IN_WRITE, ST_WRITE, C_IN_ADV, ST_PINIT, 1'b1};
      ST_WRITE: return '{OP_WRITE, RS_A,    C_ALWAYS,   ST_KINIT, C_NEVER,  ST_IDLE,  1'b0};
      ST_PINIT: return '{OP_PINIT, RS_LAST, C_NEVER,    ST_IDLE,  C_NEVER,  ST_IDLE,  1'b0};
      ST_PSCAN: return '{OP_PSCAN, RS_A,    C_LESS,     ST_SINIT, C_A_ZERO, ST_NOPIV, 1'b1};
      ST_NOPIV: return '{OP_NOPIV, RS_A,    C_ALWAYS,   ST_KINIT, C_NEVER,  ST_IDLE,  1'b0};
      ST_SINIT: return '{OP_SINIT, RS_A,    C_NEVER,    ST_IDLE,  C_NEVER,  ST_IDLE,  1'b0};
      ST_SSCAN: return '{OP_SSCAN, RS_B,    C_GREATER,  ST_RINIT, C_NEVER,  ST_IDLE,  1'b1};
      ST_RINIT: return '{OP_RINIT, RS_A,    C_NEVER,    ST_IDLE,  C_NEVER,  ST_IDLE,  1'b0};
      ST_RLOAD: return '{OP_RLOAD, RS_A,    C_A_GE_B,   ST_KINIT, C_NEVER,  ST_IDLE,  1'b0};
      ST_RSWAP: return '{OP_RSWAP, RS_B,    C_ALWAYS,   ST_RLOAD, C_NEVER,  ST_IDLE,  1'b0};
      ST_KINIT: return '{OP_KINIT, RS_K,    C_NEVER,    ST_IDLE,  C_NEVER,  ST_IDLE,  1'b0};
      ST_PACK:  return '{OP_PACK,  RS_K,    C_K_LAST,   ST_DONE,  C_NEVER,  ST_IDLE,  1'b1};
      ST_DONE:  return '{OP_DONE,  RS_K,    C_OUT_FREE, ST_IDLE,  C_NEVER,  ST_IDLE,  1'b1};
      default:  return '{OP_IDLE,  RS_A,    C_ALWAYS,   ST_IDLE,  C_NEVER,  ST_IDLE,  1'b0};
    endcase
  endfunction

endpackage

// ===== src/nlp_sequencer.sv =====
// Step counter and control store of the permutation stepper.
// Depends on nlp_pkg for the control word, status flags and program table.
module nlp_sequencer (
  input  logic            clk,
  input  logic            rst,
  input  nlp_pkg::flags_t flags,
  output nlp_pkg::ucode_t ctl
);
  import nlp_pkg::*;

  upc_t upc;
  upc_t upc_next;
  logic take_a;
  logic take_b;

  function automatic logic cond_met(input cond_t c, input flags_t f);
    case (c)
      C_NEVER:    return 1'b0;
      C_ALWAYS:   return 1'b1;
      C_IN_WRITE: return f.in_write;
      C_IN_ADV:   return f.in_adv;
      C_LESS:     return f.less;
      C_A_ZERO:   return f.a_zero;
      C_GREATER:  return f.greater;
      C_A_GE_B:   return f.a_ge_b;
      C_K_LAST:   return f.k_last;
      C_OUT_FREE: return f.out_free;
      default:    return 1'b0;
    endcase
  endfunction

  assign ctl    = ucode_rom(upc);
  assign take_a = cond_met(ctl.cond_a, flags);
  assign take_b = cond_met(ctl.cond_b, flags);

  always_comb begin
    if (take_a) begin
      upc_next = ctl.tgt_a;
    end else if (take_b) begin
      upc_next = ctl.tgt_b;
    end else if (ctl.hold) begin
      upc_next = upc;
    end else begin
      upc_next = upc + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= ST_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

// ===== src/next_lexicographic_permutation.sv =====
// Top level of the next-permutation stepper: row register file and datapath.
// Depends on nlp_pkg and nlp_sequencer.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one transaction per step:
//   action 0 writes element_value at position (positions at or past the row
//   length change nothing); action 1 advances the row to its next permutation
//   in lexicographic order, or leaves it and flags was_last if none exists.
//   Output channel (out_valid/out_ready) returns one transaction per input:
//   the row packed with element 0 in the top nibble, its base-ten value, and
//   was_last (always 0 after a write).
//   Timing: at most one row element is visited per cycle, through a single
//   read port of the row register file, driven by a microcoded step counter.
//   A write stores the element and runs the final packing pass before the
//   next acceptance; an advance first runs the pivot scan, successor scan and
//   suffix reversal (a load step and a swap step per swapped pair), then the
//   final packing pass.
//   Reset loads the identity row 0,1,2,... and leaves both channels empty.
//   A result is held in the output register until taken; the next input is
//   accepted meanwhile, and its result waits in the final step while the
//   receiver stalls.
module next_lexicographic_permutation #(
  parameter int ROW_LENGTH    = nlp_pkg::ROW_LENGTH_DEF,
  parameter int ELEMENT_WIDTH = nlp_pkg::ELEMENT_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           action,
  input  logic [nlp_pkg::POS_W-1:0]      position,
  input  logic [nlp_pkg::IN_ELEM_W-1:0]  element_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [nlp_pkg::PACKED_W-1:0]   packed_row,
  output logic [nlp_pkg::DECIMAL_W-1:0]  decimal_value,
  output logic                           was_last
);
  import nlp_pkg::*;

  localparam int IW = $clog2(ROW_LENGTH);
  localparam logic [IW-1:0] LAST_IDX = IW'(ROW_LENGTH - 1);
  localparam logic [IW-1:0] PREV_IDX = IW'(ROW_LENGTH - 2);
  localparam logic [POS_W:0] ROW_LEN_EXT = (POS_W + 1)'(ROW_LENGTH);

  typedef logic [ELEMENT_WIDTH-1:0] elem_t;

  // Row storage and working registers
  elem_t          row [ROW_LENGTH];
  elem_t          nxt;      // element right of the pivot candidate
  elem_t          pv;       // pivot value
  elem_t          tmp;      // swap holding register
  elem_t          val_r;
  logic [POS_W-1:0] pos_r;
  logic [IW-1:0]  a;        // pivot, then low end of the suffix
  logic [IW-1:0]  b;        // successor, then high end of the suffix
  logic [IW-1:0]  k;        // packing index
  logic           last_r;
  logic [PACKED_W-1:0]  acc_p;
  logic [DECIMAL_W-1:0] acc_d;

  ucode_t         ctl;
  flags_t         flags;
  logic [IW-1:0]  rd_idx;
  elem_t          rd;
  logic           in_acc;
  logic           pos_ok;
  logic           found_piv;
  logic           found_succ;
  logic           out_load;

  nlp_sequencer u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctl   (ctl)
  );

  // Single read port of the row
  always_comb begin
    case (ctl.rsel)
      RS_A:    rd_idx = a;
      RS_B:    rd_idx = b;
      RS_K:    rd_idx = k;
      RS_LAST: rd_idx = LAST_IDX;
      default: rd_idx = a;
    endcase
  end
  assign rd = row[rd_idx];

  assign in_ready   = (ctl.op == OP_IDLE);
  assign in_acc     = in_valid && in_ready;
  assign pos_ok     = ({1'b0, pos_r} < ROW_LEN_EXT);
  assign found_piv  = (rd < nxt);
  assign found_succ = (rd > pv);
  assign out_load   = (ctl.op == OP_DONE) && flags.out_free;

  always_comb begin
    flags.in_write = in_valid && !action;
    flags.in_adv   = in_valid && action;
    flags.less     = found_piv;
    flags.a_zero   = (a == '0);
    flags.greater  = found_succ;
    flags.a_ge_b   = (a >= b);
    flags.k_last   = (k == LAST_IDX);
    flags.out_free = !out_valid || out_ready;
  end

  // Row register file: identity after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ROW_LENGTH; i++) begin
        row[i] <= ELEMENT_WIDTH'(i);
      end
    end else begin
      case (ctl.op)
        OP_WRITE: begin
          if (pos_ok) begin
            row[pos_r[IW-1:0]] <= val_r;
          end
        end
        OP_SSCAN: begin
          // swap pivot with the first greater element from the right
          if (found_succ) begin
            row[a] <= rd;
            row[b] <= pv;
          end
        end
        OP_RSWAP: begin
          row[a] <= rd;
          row[b] <= tmp;
        end
        default: ;
      endcase
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      last_r <= 1'b0;
    end else begin
      case (ctl.op)
        OP_IDLE:  if (in_acc) last_r <= 1'b0;
        OP_NOPIV: last_r <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_IDLE: begin
        if (in_acc) begin
          pos_r <= position;
          val_r <= ELEMENT_WIDTH'(element_value);
        end
      end
      OP_PINIT: begin
        nxt <= rd;
        a   <= PREV_IDX;
      end
      OP_PSCAN: begin
        // walk left until an element is below its right neighbor
        pv <= rd;
        if (!found_piv) begin
          nxt <= rd;
          a   <= a - 1'b1;
        end
      end
      OP_SINIT: b <= LAST_IDX;
      OP_SSCAN: begin
        if (!found_succ) begin
          b <= b - 1'b1;
        end
      end
      OP_RINIT: begin
        a <= a + 1'b1;
        b <= LAST_IDX;
      end
      OP_RLOAD: tmp <= rd;
      OP_RSWAP: begin
        a <= a + 1'b1;
        b <= b - 1'b1;
      end
      OP_KINIT: begin
        k     <= '0;
        acc_p <= '0;
        acc_d <= '0;
      end
      OP_PACK: begin
        k     <= k + 1'b1;
        acc_p <= (acc_p << ELEMENT_WIDTH) | PACKED_W'(rd);
        acc_d <= (acc_d << 3) + (acc_d << 1) + DECIMAL_W'(rd);
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      packed_row    <= acc_p;
      decimal_value <= acc_d;
      was_last      <= last_r;
    end
  end

  // Leave the idle step right after taking a transaction
  a_leave_idle: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !in_ready)
    else $error("in_ready still high after an accepted transaction");

  // Successor scan never crosses the pivot
  a_succ_right: assert property (@(posedge clk) disable iff (rst)
    (ctl.op == OP_SSCAN) |-> (b > a))
    else $error("successor scan reached the pivot");

  // Suffix swaps only with the low end below the high end
  a_swap_order: assert property (@(posedge clk) disable iff (rst)
    (ctl.op == OP_RSWAP) |-> (a < b))
    else $error("suffix swap with crossed pointers");

  // A new result appears only from the final step
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(ctl.op == OP_DONE))
    else $error("out_valid raised outside the final step");

endmodule
